/* rtl/dnr_pkg.sv */
// Shared types and constants for the directional nearest rectangle search.
package dnr_pkg;

  // Field widths.
  localparam int COORD_BITS     = 14;
  localparam int ID_BITS        = 8;
  localparam int DIR_BITS       = 2;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = COORD_BITS;

  // A doubled centre (2*x + w) needs two bits more than a coordinate.
  localparam int GAP_BITS       = COORD_BITS + 2;
  // along * 256 + across * 77 fits in this many bits.
  localparam int DIST_BITS      = COORD_BITS + 11;
  localparam int ACROSS_WEIGHT  = 77;

  // Candidates past this count within one search are ignored for the minimum.
  localparam int MAX_CANDIDATES = 256;
  localparam int CNT_BITS       = $clog2(MAX_CANDIDATES + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ID_BITS-1:0]    id_t;
  typedef logic [DIST_BITS-1:0]  dist_t;
  typedef logic [GAP_BITS-1:0]   gap_t;

  // Search side.
  typedef enum logic [DIR_BITS-1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FOCUS_X   = 3'd0,
    REG_FOCUS_Y   = 3'd1,
    REG_FOCUS_W   = 3'd2,
    REG_FOCUS_H   = 3'd3,
    REG_FOCUS_ID  = 3'd4,
    REG_DIRECTION = 3'd5
  } cfg_idx_t;

  // Current focus settings.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    id_t    id;
    dir_t   dir;
  } focus_t;

  // One scored candidate on its way to the running minimum.
  typedef struct packed {
    logic  qual;
    dist_t metric;
    id_t   id;
    logic  last;
  } score_t;

endpackage

/* rtl/dnr_cfg.sv */
// Configuration registers holding the focused rectangle and search side.
module dnr_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dnr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [dnr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output dnr_pkg::focus_t                      focus
);
  import dnr_pkg::*;

  focus_t focus_r;
  focus_t focus_nxt;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Decode the register index; unknown indexes leave everything as is.
  always_comb begin
    focus_nxt = focus_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_FOCUS_X:   focus_nxt.x   = cfg_data[COORD_BITS-1:0];
        REG_FOCUS_Y:   focus_nxt.y   = cfg_data[COORD_BITS-1:0];
        REG_FOCUS_W:   focus_nxt.w   = cfg_data[COORD_BITS-1:0];
        REG_FOCUS_H:   focus_nxt.h   = cfg_data[COORD_BITS-1:0];
        REG_FOCUS_ID:  focus_nxt.id  = cfg_data[ID_BITS-1:0];
        REG_DIRECTION: focus_nxt.dir = dir_t'(cfg_data[DIR_BITS-1:0]);
        default:       focus_nxt     = focus_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_r <= '0;
    end else begin
      focus_r <= focus_nxt;
    end
  end

  assign focus = focus_r;

endmodule

/* rtl/dnr_dist.sv */
// Input register and distance stage: side test and weighted centre distance.
module dnr_dist (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dnr_pkg::ID_BITS-1:0]      in_cand_id,
  input  logic [dnr_pkg::COORD_BITS-1:0]   in_cand_x,
  input  logic [dnr_pkg::COORD_BITS-1:0]   in_cand_y,
  input  logic [dnr_pkg::COORD_BITS-1:0]   in_cand_w,
  input  logic [dnr_pkg::COORD_BITS-1:0]   in_cand_h,
  input  logic                             in_last_cand,
  input  dnr_pkg::focus_t                  focus,
  output logic                             score_valid,
  input  logic                             score_ready,
  output dnr_pkg::score_t                  score
);
  import dnr_pkg::*;

  // Input stage registers.
  logic   s1_valid_r, s1_valid_nxt;
  id_t    s1_id_r;
  coord_t s1_x_r, s1_y_r, s1_w_r, s1_h_r;
  logic   s1_last_r;

  logic in_take;

  logic [COORD_BITS:0] cand_right, cand_bottom, focus_right, focus_bottom;
  logic  side;
  gap_t  fcx, fcy, ccx, ccy, gx, gy, along, across;
  dist_t metric;

  // Flow control: the input register frees up when it is empty or its candidate is scored.
  assign in_ready = !s1_valid_r || score_ready;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt = in_take ? 1'b1 : (score_ready ? 1'b0 : s1_valid_r);

  // Side test against the focused rectangle's edges.
  always_comb begin
    cand_right   = {1'b0, s1_x_r} + {1'b0, s1_w_r};
    cand_bottom  = {1'b0, s1_y_r} + {1'b0, s1_h_r};
    focus_right  = {1'b0, focus.x} + {1'b0, focus.w};
    focus_bottom = {1'b0, focus.y} + {1'b0, focus.h};
    case (focus.dir)
      DIR_LEFT:  side = cand_right <= {1'b0, focus.x};
      DIR_RIGHT: side = {1'b0, s1_x_r} >= focus_right;
      DIR_UP:    side = cand_bottom <= {1'b0, focus.y};
      DIR_DOWN:  side = {1'b0, s1_y_r} >= focus_bottom;
      default:   side = 1'b0;
    endcase
  end

  // Doubled centre gaps and the weighted distance.
  always_comb begin
    fcx = {1'b0, focus.x, 1'b0} + {2'b00, focus.w};
    fcy = {1'b0, focus.y, 1'b0} + {2'b00, focus.h};
    ccx = {1'b0, s1_x_r, 1'b0} + {2'b00, s1_w_r};
    ccy = {1'b0, s1_y_r, 1'b0} + {2'b00, s1_h_r};
    gx  = (fcx >= ccx) ? (fcx - ccx) : (ccx - fcx);
    gy  = (fcy >= ccy) ? (fcy - ccy) : (ccy - fcy);
    if (focus.dir == DIR_LEFT || focus.dir == DIR_RIGHT) begin
      along  = gx;
      across = gy;
    end else begin
      along  = gy;
      across = gx;
    end
    metric = {1'b0, along, 8'h00}
           + (DIST_BITS'(across) * DIST_BITS'(ACROSS_WEIGHT));
  end

  // Scored candidate handed straight to the running minimum.
  always_comb begin
    score.qual   = side && (s1_id_r != focus.id);
    score.metric = metric;
    score.id     = s1_id_r;
    score.last   = s1_last_r;
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_id_r   <= in_cand_id;
      s1_x_r    <= in_cand_x;
      s1_y_r    <= in_cand_y;
      s1_w_r    <= in_cand_w;
      s1_h_r    <= in_cand_h;
      s1_last_r <= in_last_cand;
    end
  end

  assign score_valid = s1_valid_r;

endmodule

/* rtl/dnr_best.sv */
// Running minimum over one search and the result register.
module dnr_best (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         score_valid,
  output logic                         score_ready,
  input  dnr_pkg::score_t              score,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [dnr_pkg::ID_BITS-1:0]  out_best_id
);
  import dnr_pkg::*;

  dist_t               best_metric_r, best_metric_nxt;
  id_t                 best_id_r, best_id_nxt;
  logic                have_r, have_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  logic out_valid_r, out_valid_nxt;
  logic found_r, found_nxt;
  id_t  res_id_r, res_id_nxt;

  logic take;

  // A last candidate waits only if the result register is still occupied.
  assign score_ready = !score.last || !out_valid_r || out_ready;
  assign take        = score_valid && score_ready;

  // Update the running minimum; the earlier candidate wins a tie.
  always_comb begin
    best_metric_nxt = best_metric_r;
    best_id_nxt     = best_id_r;
    have_nxt        = have_r;
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    res_id_nxt      = res_id_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (take) begin
      if (cnt_r < CNT_BITS'(MAX_CANDIDATES)) begin
        cnt_nxt = cnt_r + 1'b1;
        if (score.qual && (!have_r || score.metric < best_metric_r)) begin
          best_metric_nxt = score.metric;
          best_id_nxt     = score.id;
          have_nxt        = 1'b1;
        end
      end
      if (score.last) begin
        out_valid_nxt   = 1'b1;
        found_nxt       = have_nxt;
        res_id_nxt      = have_nxt ? best_id_nxt : '0;
        best_metric_nxt = '1;
        best_id_nxt     = '0;
        have_nxt        = 1'b0;
        cnt_nxt         = '0;
      end
    end
  end

  // Search state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_metric_r <= '1;
      best_id_r     <= '0;
      have_r        <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      best_metric_r <= best_metric_nxt;
      best_id_r     <= best_id_nxt;
      have_r        <= have_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    res_id_r <= res_id_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_found   = found_r;
  assign out_best_id = res_id_r;

endmodule

/* rtl/directional_nearest_rectangle.sv */
// Top level of the directional nearest rectangle search.
// Candidates stream in at one request per clock while in_ready is high. Each
// is held in an input register, from which combinational side, distance and
// compare logic updates the running minimum and then the result register, and
// the next search's first candidate may follow the last one with no gap. The
// result register lets input continue while a result waits; only a second
// last candidate stalls the input behind an untaken result. The user must
// write focus and direction through the cfg_ port (always ready) only while
// no search is in flight; the block itself does not enforce this.
module directional_nearest_rectangle (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dnr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dnr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dnr_pkg::ID_BITS-1:0]         in_cand_id,
  input  logic [dnr_pkg::COORD_BITS-1:0]      in_cand_x,
  input  logic [dnr_pkg::COORD_BITS-1:0]      in_cand_y,
  input  logic [dnr_pkg::COORD_BITS-1:0]      in_cand_w,
  input  logic [dnr_pkg::COORD_BITS-1:0]      in_cand_h,
  input  logic                                in_last_cand,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [dnr_pkg::ID_BITS-1:0]         out_best_id
);
  import dnr_pkg::*;

  focus_t focus;
  score_t score;
  logic   score_valid;
  logic   score_ready;

  // Focus registers.
  dnr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .focus     (focus)
  );

  // Side test and distance.
  dnr_dist u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cand_id   (in_cand_id),
    .in_cand_x    (in_cand_x),
    .in_cand_y    (in_cand_y),
    .in_cand_w    (in_cand_w),
    .in_cand_h    (in_cand_h),
    .in_last_cand (in_last_cand),
    .focus        (focus),
    .score_valid  (score_valid),
    .score_ready  (score_ready),
    .score        (score)
  );

  // Running minimum and result.
  dnr_best u_best (
    .clk         (clk),
    .rst_n       (rst_n),
    .score_valid (score_valid),
    .score_ready (score_ready),
    .score       (score),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_found   (out_found),
    .out_best_id (out_best_id)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the directional nearest rectangle search block.
`timescale 1ns / 1ps

module tb_top;
  import dnr_pkg::*;

  localparam int ITEMS       = 1800;
  localparam int CALM_ITEMS  = 200;
  localparam int SETTLE      = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int NUM_REGS    = int'(REG_DIRECTION) + 1;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_addr_t;

  // One candidate request as it goes onto the input ports.
  typedef struct packed {
    id_t    id;
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    logic   last;
  } cand_t;

  // One search outcome as it comes off the result ports.
  typedef struct packed {
    logic found;
    id_t  best_id;
  } pick_t;

  typedef enum logic { ROW_CFG, ROW_CAND } row_kind_t;

  // A line of the directed plan: a register write or a candidate.
  typedef struct {
    row_kind_t kind;
    cfg_addr_t idx;
    cfg_word_t data;
    cand_t     cand;
    bit        typed;
    pick_t     pick;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_addr_t cfg_index;
  cfg_word_t cfg_data;
  logic      in_valid;
  logic      in_ready;
  id_t       in_cand_id;
  coord_t    in_cand_x;
  coord_t    in_cand_y;
  coord_t    in_cand_w;
  coord_t    in_cand_h;
  logic      in_last_cand;
  logic      out_valid;
  logic      out_ready;
  logic      out_found;
  id_t       out_best_id;

  directional_nearest_rectangle dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cand_id   (in_cand_id),
    .in_cand_x    (in_cand_x),
    .in_cand_y    (in_cand_y),
    .in_cand_w    (in_cand_w),
    .in_cand_h    (in_cand_h),
    .in_last_cand (in_last_cand),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_best_id  (out_best_id)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the focus settings and of the running minimum.
  focus_t focus;
  dist_t  best_metric;
  id_t    best_id;
  bit     have_best;
  int     seen_cands;

  pick_t     pending_picks[$];
  plan_row_t plan[$];

  bit cfg_open  = 1'b0;
  bit calm      = 1'b0;
  bit idle_on   = 1'b1;
  int n_items   = 0;
  int n_searches = 0;
  int n_writes  = 0;
  int n_checked = 0;
  int n_hits    = 0;
  int n_bad     = 0;
  int quiet     = 0;

  task automatic clear_search();
    best_metric = '1;
    best_id     = '0;
    have_best   = 1'b0;
    seen_cands  = 0;
  endtask

  // Scores one accepted candidate; on a last mark it hands back the search outcome.
  task automatic score_candidate(input cand_t c, output bit done, output pick_t pick);
    bit on_side;
    int gx;
    int gy;
    int along;
    int across;
    int metric;
    done = 1'b0;
    pick = '0;
    if (seen_cands < MAX_CANDIDATES) begin
      seen_cands++;
      case (focus.dir)
        DIR_LEFT:  on_side = (int'(c.x) + int'(c.w)) <= int'(focus.x);
        DIR_RIGHT: on_side = int'(c.x) >= (int'(focus.x) + int'(focus.w));
        DIR_UP:    on_side = (int'(c.y) + int'(c.h)) <= int'(focus.y);
        default:   on_side = int'(c.y) >= (int'(focus.y) + int'(focus.h));
      endcase
      if (on_side && c.id != focus.id) begin
        // Centres are compared in doubled units so they stay integers.
        gx = 2 * int'(focus.x) + int'(focus.w) - 2 * int'(c.x) - int'(c.w);
        gy = 2 * int'(focus.y) + int'(focus.h) - 2 * int'(c.y) - int'(c.h);
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        along  = (focus.dir == DIR_LEFT || focus.dir == DIR_RIGHT) ? gx : gy;
        across = (focus.dir == DIR_LEFT || focus.dir == DIR_RIGHT) ? gy : gx;
        metric = along * 256 + across * ACROSS_WEIGHT;
        if (!have_best || dist_t'(metric) < best_metric) begin
          best_metric = dist_t'(metric);
          best_id     = c.id;
          have_best   = 1'b1;
        end
      end
    end
    if (c.last) begin
      done         = 1'b1;
      pick.found   = have_best;
      pick.best_id = have_best ? best_id : '0;
      clear_search();
    end
  endtask

  // Waits until every outcome has come back and the pipeline has drained.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register; consecutive writes keep cfg_valid high.
  task automatic cfg_write(input cfg_addr_t idx, input cfg_word_t data);
    if (!cfg_open) begin
      settle_block();
      cfg_open = 1'b1;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_writes++;
    case (idx)
      REG_FOCUS_X:   focus.x   = data[COORD_BITS-1:0];
      REG_FOCUS_Y:   focus.y   = data[COORD_BITS-1:0];
      REG_FOCUS_W:   focus.w   = data[COORD_BITS-1:0];
      REG_FOCUS_H:   focus.h   = data[COORD_BITS-1:0];
      REG_FOCUS_ID:  focus.id  = data[ID_BITS-1:0];
      REG_DIRECTION: focus.dir = dir_t'(data[DIR_BITS-1:0]);
      default: ;
    endcase
  endtask

  // Sends one candidate request, with an optional idle burst ahead of it.
  task automatic send_cand(input cand_t c, input bit typed, input pick_t typed_pick);
    int    gap;
    bit    done;
    pick_t pick;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    gap = 0;
    if (!calm && idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cand_id   <= c.id;
    in_cand_x    <= c.x;
    in_cand_y    <= c.y;
    in_cand_w    <= c.w;
    in_cand_h    <= c.h;
    in_last_cand <= c.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    score_candidate(c, done, pick);
    if (done) begin
      pending_picks.push_back(typed ? typed_pick : pick);
      n_searches++;
    end
  endtask

  task automatic plan_cfg(input cfg_addr_t idx, input cfg_word_t data);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = data;
    row.cand  = '0;
    row.typed = 1'b0;
    row.pick  = '0;
    plan.push_back(row);
  endtask

  task automatic plan_cand(input id_t id, input coord_t x, input coord_t y, input coord_t w,
                           input coord_t h, input logic last, input bit typed,
                           input logic found, input id_t best);
    plan_row_t row;
    row.kind  = ROW_CAND;
    row.idx   = '0;
    row.data  = '0;
    row.cand  = {id, x, y, w, h, last};
    row.typed = typed;
    row.pick  = {found, best};
    plan.push_back(row);
  endtask

  function automatic coord_t clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  // Random candidate, mostly scattered around the focus so that every side gets hits.
  function automatic cand_t make_cand(input cand_t prev, input logic last);
    cand_t c;
    int    roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      c.x = coord_t'($urandom);
      c.y = coord_t'($urandom);
      c.w = coord_t'($urandom);
      c.h = coord_t'($urandom);
    end else if (roll == 1) begin
      // Same geometry as the previous candidate gives an exact tie.
      c.x = prev.x;
      c.y = prev.y;
      c.w = prev.w;
      c.h = prev.h;
    end else begin
      c.w = coord_t'($urandom_range(0, 800));
      c.h = coord_t'($urandom_range(0, 800));
      c.x = clamp_coord(int'(focus.x) + int'(focus.w) / 2 + int'($urandom_range(0, 8000)) - 4000);
      c.y = clamp_coord(int'(focus.y) + int'(focus.h) / 2 + int'($urandom_range(0, 8000)) - 4000);
    end
    c.id   = (roll == 2) ? focus.id : id_t'($urandom);
    c.last = last;
    return c;
  endfunction

  // Result side: random ready stalls, and a check of every accepted result.
  initial begin : result_side
    int    hold;
    bit    rdy;
    pick_t want;
    hold = 0;
    rdy  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_picks.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("Unexpected result: found=%0d best_id=0x%02h", out_found, out_best_id);
        end else begin
          want = pending_picks.pop_front();
          n_checked++;
          if (want.found) n_hits++;
          if (out_found !== want.found || out_best_id !== want.best_id) begin
            n_bad++;
            if (n_bad <= REPORT_MAX)
              $display("Mismatch %0d: expected found=%0d id=0x%02h, got found=%0d id=0x%02h",
                       n_checked, want.found, want.best_id, out_found, out_best_id);
          end
        end
      end
      if (calm) begin
        rdy = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if (rdy && $urandom_range(0, 1) == 1) begin
        rdy  = 1'b0;
        hold = $urandom_range(1, 18) - 1;
      end else begin
        rdy  = 1'b1;
        hold = $urandom_range(0, 30);
      end
      out_ready <= rdy;
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no request accepted for %0d cycles", quiet);
      $display("FAIL directional_nearest_rectangle");
      $finish;
    end
  end

  // Stimulus: directed plan first, then random phases of settings and searches.
  initial begin : stimulus
    cand_t     c;
    cand_t     prev;
    cfg_word_t v;
    bit        extreme;
    int        phase;
    int        n_srch;
    int        n_len;
    int        waited;

    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_cand_id   <= '0;
    in_cand_x    <= '0;
    in_cand_y    <= '0;
    in_cand_w    <= '0;
    in_cand_h    <= '0;
    in_last_cand <= 1'b0;
    focus = '0;
    clear_search();
    prev = '0;

    // Reset state: focus all zero, looking left.
    plan_cand(8'h05, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1, 8'h05);
    plan_cand(8'h00, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0, 8'h00);
    plan_cand(8'hFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b1, 1'b1, 1'b0, 8'h00);
    // Looking right: an edge-touching hit, a farther one, the focused id, an overlap.
    plan_cfg(REG_FOCUS_X, 8000);
    plan_cfg(REG_FOCUS_Y, 8000);
    plan_cfg(REG_FOCUS_W, 200);
    plan_cfg(REG_FOCUS_H, 100);
    plan_cfg(REG_FOCUS_ID, 14'h003C);
    plan_cfg(REG_DIRECTION, cfg_word_t'(DIR_RIGHT));
    plan_cand(8'h10, 8200, 8000, 50, 100, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'h11, 9000, 8000, 50, 100, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'h3C, 8200, 8000, 10, 10, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'h12, 8199, 8000, 50, 100, 1'b1, 1'b0, 1'b0, 8'h00);
    // Looking up, with spare high bits in the write: a tie that the earlier one wins.
    plan_cfg(REG_DIRECTION, 14'h3FFE);
    plan_cand(8'h21, 7900, 7000, 200, 100, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'h20, 8100, 7000, 200, 100, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'h30, 8000, 7901, 200, 100, 1'b1, 1'b0, 1'b0, 8'h00);
    // Writes past the last register are dropped; zero-size focus, looking down.
    plan_cfg(cfg_addr_t'(NUM_REGS), 14'h3FFF);
    plan_cfg(cfg_addr_t'(NUM_REGS + 1), 14'h3FFF);
    plan_cfg(REG_FOCUS_ID, 14'h3F55);
    plan_cfg(REG_FOCUS_W, 0);
    plan_cfg(REG_FOCUS_H, 0);
    plan_cfg(REG_DIRECTION, cfg_word_t'(DIR_DOWN));
    plan_cand(8'h55, 8000, 9000, 0, 0, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'hAA, 0, 8000, 0, 0, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'h01, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b1, 1'b0, 1'b0, 8'h00);
    // Focus at the far corner, looking left: largest distances.
    plan_cfg(REG_FOCUS_X, 14'h3FFF);
    plan_cfg(REG_FOCUS_W, 14'h3FFF);
    plan_cfg(REG_FOCUS_Y, 0);
    plan_cfg(REG_DIRECTION, cfg_word_t'(DIR_LEFT));
    plan_cand(8'h02, 0, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b0, 1'b0, 1'b0, 8'h00);
    plan_cand(8'h03, 0, 0, 14'h3FFF, 0, 1'b1, 1'b0, 1'b0, 8'h00);
    // Nothing can lie right of a focus that reaches past the coordinate range.
    plan_cfg(REG_DIRECTION, cfg_word_t'(DIR_RIGHT));
    plan_cand(8'h04, 14'h3FFF, 0, 0, 0, 1'b1, 1'b1, 1'b0, 8'h00);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        cfg_write(plan[i].idx, plan[i].data);
      else
        send_cand(plan[i].cand, plan[i].typed, plan[i].pick);
    end

    // Random phases: fresh settings, then a handful of searches under them.
    phase = 0;
    while (n_items < ITEMS) begin
      phase++;
      extreme = (phase % 4 == 0);
      for (int r = 0; r < NUM_REGS; r++) begin
        if (r >= int'(REG_FOCUS_ID))
          v = cfg_word_t'($urandom);
        else if (extreme)
          v = ($urandom_range(0, 1) == 1) ? cfg_word_t'(COORD_MAX) : '0;
        else if (r == int'(REG_FOCUS_X) || r == int'(REG_FOCUS_Y))
          v = cfg_word_t'($urandom_range(1000, 15000));
        else
          v = cfg_word_t'($urandom_range(0, 1500));
        cfg_write(cfg_addr_t'(r), v);
      end
      if ($urandom_range(0, 2) == 0)
        cfg_write(cfg_addr_t'(NUM_REGS + $urandom_range(0, 1)), cfg_word_t'($urandom));

      calm    = (n_items >= ITEMS - CALM_ITEMS);
      idle_on = !calm && ($urandom_range(0, 3) != 0);
      n_srch  = $urandom_range(4, 12);
      for (int s = 0; s < n_srch; s++) begin
        // A couple of searches run past the candidate limit.
        if ((phase == 3 || phase == 7) && s == 0)
          n_len = $urandom_range(MAX_CANDIDATES + 1, MAX_CANDIDATES + 24);
        else
          n_len = $urandom_range(1, 12);
        for (int k = 0; k < n_len; k++) begin
          c = make_cand(prev, k == n_len - 1);
          send_cand(c, 1'b0, '0);
          prev = c;
        end
        calm = (n_items >= ITEMS - CALM_ITEMS);
        if (calm) idle_on = 1'b0;
      end
    end

    // Drain the outstanding results, then let the pipeline empty.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_picks.size() != 0 && waited < QUIET_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_picks.size() != 0)
      $display("%0d expected results never arrived", pending_picks.size());
    n_bad += pending_picks.size();

    $display("Covered %0d candidates in %0d searches over %0d register settings (%0d writes).",
             n_items, n_searches, phase + 5, n_writes);
    $display("Checked %0d results, %0d of them with a hit; %0d failures.",
             n_checked, n_hits, n_bad);
    if (n_bad == 0)
      $display("PASS directional_nearest_rectangle");
    else
      $display("FAIL directional_nearest_rectangle");
    $finish;
  end

endmodule
